### rtl/modexp_pkg.sv
package modexp_pkg;

  // widths of the fields on the ports
  localparam int FIELD_W = 32;

  // default operand width
  localparam int MOD_WIDTH_DEF = 32;

  // configuration register map
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 1'b1;

  localparam logic [FIELD_W-1:0] MODULUS_RST  = 32'd2;
  localparam logic [FIELD_W-1:0] EXPONENT_RST = 32'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_NEXT,
    ST_MULT,
    ST_SHIFT,
    ST_SQUARE,
    ST_DONE
  } state_t;

endpackage

### rtl/modular_exponentiation_unit.sv
// channel   direction  ports                          transfer when
// -------   ---------  -----------------------------  ---------------------
// input     in         start, base_value              start high, busy low
// result    out        done, power_result             done high (one cycle)
// config    in         cfg_write, cfg_index, cfg_data cfg_write high
//
// each base runs through a reduction of the base, then a multiply for every one bit
// and a square for every further bit of the exponent; a zero exponent ends after the
// reduction and a zero modulus goes straight to the result. the shared shift-add-reduce
// unit handles one multiplier bit per cycle. busy stays high from the accepted start to
// the result cycle, and the next start is taken in the cycle after the result. reset is
// synchronous and returns modulus 2, exponent 1. the receiver cannot stall: each result
// is shown for one cycle.
module modular_exponentiation_unit #(
  parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [modexp_pkg::FIELD_W-1:0]      base_value,
  output logic                                done,
  output logic [modexp_pkg::FIELD_W-1:0]      power_result,
  input  logic                                cfg_write,
  input  logic [modexp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [modexp_pkg::FIELD_W-1:0]      cfg_data
);

  localparam int W  = MOD_WIDTH;
  localparam int FW = modexp_pkg::FIELD_W;
  localparam int CW = $clog2(MOD_WIDTH + 1);

  modexp_pkg::state_t state, state_next;

  logic [FW-1:0] modulus;
  logic [FW-1:0] exponent;

  logic [W-1:0]  m_op, e_op, b_op;
  logic [W-1:0]  acc, acc_next;
  logic [W-1:0]  sq, sq_next;
  logic [W-1:0]  ebits, ebits_next;
  logic [W-1:0]  op_a, op_a_next;
  logic [W-1:0]  op_b, op_b_next;
  logic [W-1:0]  part, part_next;
  logic [CW-1:0] count, count_next;

  logic [W+1:0]  sum, m1, m2;
  logic [W-1:0]  step;
  logic          last;
  logic [W-1:0]  ebits_shr;

  // operands are the fields taken modulo 2^MOD_WIDTH
  if (W > FW) begin : g_wide
    assign m_op = {{(W-FW){1'b0}}, modulus};
    assign e_op = {{(W-FW){1'b0}}, exponent};
    assign b_op = {{(W-FW){1'b0}}, base_value};
  end else begin : g_narrow
    assign m_op = modulus[W-1:0];
    assign e_op = exponent[W-1:0];
    assign b_op = base_value[W-1:0];
  end

  if (W >= FW) begin : g_out_trunc
    assign power_result = acc[FW-1:0];
  end else begin : g_out_ext
    assign power_result = {{(FW-W){1'b0}}, acc};
  end

  // shared unit: part = 2*part + a_bit*b, reduced; part and b stay below m
  always_comb begin
    sum  = {1'b0, part, 1'b0} + {2'b00, (op_a[W-1] ? op_b : {W{1'b0}})};
    m1   = {2'b00, m_op};
    m2   = {1'b0, m_op, 1'b0};
    if (sum >= m2) begin
      step = W'(sum - m2);
    end else if (sum >= m1) begin
      step = W'(sum - m1);
    end else begin
      step = sum[W-1:0];
    end
  end

  assign last      = (count == CW'(1));
  assign ebits_shr = ebits >> 1;

  assign busy = (state != modexp_pkg::ST_IDLE);
  assign done = (state == modexp_pkg::ST_DONE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (m_op == '0) ? modexp_pkg::ST_DONE : modexp_pkg::ST_REDUCE;
        end
      end
      modexp_pkg::ST_REDUCE: begin
        if (last) state_next = modexp_pkg::ST_NEXT;
      end
      modexp_pkg::ST_NEXT: begin
        if (ebits == '0) begin
          state_next = modexp_pkg::ST_DONE;
        end else if (ebits[0]) begin
          state_next = modexp_pkg::ST_MULT;
        end else begin
          state_next = modexp_pkg::ST_SHIFT;
        end
      end
      modexp_pkg::ST_MULT: begin
        if (last) state_next = modexp_pkg::ST_SHIFT;
      end
      modexp_pkg::ST_SHIFT: begin
        state_next = (ebits_shr != '0) ? modexp_pkg::ST_SQUARE : modexp_pkg::ST_DONE;
      end
      modexp_pkg::ST_SQUARE: begin
        if (last) state_next = modexp_pkg::ST_NEXT;
      end
      modexp_pkg::ST_DONE: begin
        state_next = modexp_pkg::ST_IDLE;
      end
      default: begin
        state_next = modexp_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath control
  always_comb begin
    acc_next   = acc;
    sq_next    = sq;
    ebits_next = ebits;
    op_a_next  = op_a;
    op_b_next  = op_b;
    part_next  = part;
    count_next = count;
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (start) begin
          // 1 mod m, which is 0 for m of 0 or 1
          acc_next   = (m_op > W'(1)) ? W'(1) : '0;
          ebits_next = e_op;
          // base mod m as base * (1 mod m)
          op_a_next  = b_op;
          op_b_next  = (m_op > W'(1)) ? W'(1) : '0;
          part_next  = '0;
          count_next = CW'(W);
        end
      end
      modexp_pkg::ST_REDUCE,
      modexp_pkg::ST_MULT,
      modexp_pkg::ST_SQUARE: begin
        op_a_next  = op_a << 1;
        part_next  = step;
        count_next = count - CW'(1);
        if (last) begin
          if (state == modexp_pkg::ST_MULT) begin
            acc_next = step;
          end else begin
            sq_next = step;
          end
        end
      end
      modexp_pkg::ST_NEXT: begin
        if (ebits[0]) begin
          op_a_next  = acc;
          op_b_next  = sq;
          part_next  = '0;
          count_next = CW'(W);
        end
      end
      modexp_pkg::ST_SHIFT: begin
        ebits_next = ebits_shr;
        op_a_next  = sq;
        op_b_next  = sq;
        part_next  = '0;
        count_next = CW'(W);
      end
      modexp_pkg::ST_DONE: begin
        acc_next = acc;
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= modexp_pkg::ST_IDLE;
      modulus  <= modexp_pkg::MODULUS_RST;
      exponent <= modexp_pkg::EXPONENT_RST;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          modexp_pkg::REG_MODULUS:  modulus  <= cfg_data;
          modexp_pkg::REG_EXPONENT: exponent <= cfg_data;
          default: begin
            modulus <= modulus;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      sq    <= '0;
      ebits <= '0;
      op_a  <= '0;
      op_b  <= '0;
      part  <= '0;
      count <= '0;
    end else begin
      acc   <= acc_next;
      sq    <= sq_next;
      ebits <= ebits_next;
      op_a  <= op_a_next;
      op_b  <= op_b_next;
      part  <= part_next;
      count <= count_next;
    end
  end

endmodule

### bench/tb.sv
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 10000;
  localparam logic [modexp_pkg::FIELD_W-1:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [modexp_pkg::FIELD_W-1:0] base_value = '0;
  logic done;
  logic [modexp_pkg::FIELD_W-1:0] power_result;
  logic cfg_write = 1'b0;
  logic [modexp_pkg::CFG_INDEX_W-1:0] cfg_index = modexp_pkg::REG_MODULUS;
  logic [modexp_pkg::FIELD_W-1:0] cfg_data = '0;

  // copy of the key registers as the block should hold them
  logic [modexp_pkg::FIELD_W-1:0] modulus_copy = modexp_pkg::MODULUS_RST;
  logic [modexp_pkg::FIELD_W-1:0] exponent_copy = modexp_pkg::EXPONENT_RST;

  logic [modexp_pkg::FIELD_W-1:0] pending_powers[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  modular_exponentiation_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .base_value(base_value),
    .done(done),
    .power_result(power_result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // right-to-left square-and-multiply; 64-bit products never overflow
  function automatic logic [modexp_pkg::FIELD_W-1:0] power_mod(
      input logic [modexp_pkg::FIELD_W-1:0] b,
      input logic [modexp_pkg::FIELD_W-1:0] m_in,
      input logic [modexp_pkg::FIELD_W-1:0] e_in);
    bit [63:0] m;
    bit [63:0] acc;
    bit [63:0] sq;
    bit [63:0] e;
    m = m_in;
    e = e_in;
    if (m == 0) begin
      return '0;
    end
    sq = b % m;
    acc = 64'd1 % m;
    while (e != 0) begin
      if (e[0]) begin
        acc = (acc * sq) % m;
      end
      e = e >> 1;
      if (e != 0) begin
        sq = (sq * sq) % m;
      end
    end
    return acc[modexp_pkg::FIELD_W-1:0];
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [modexp_pkg::FIELD_W-1:0] want,
                                 input logic [modexp_pkg::FIELD_W-1:0] got);
    $display("mismatch: %s expected %h got %h", what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_powers.size() == 0) begin
        report_mismatch("unexpected result", '0, power_result);
      end else if (power_result !== pending_powers[0]) begin
        report_mismatch("power_result", pending_powers[0], power_result);
        void'(pending_powers.pop_front());
      end else begin
        void'(pending_powers.pop_front());
      end
    end
  end

  // cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout waiting for a transfer");
        $display("** modular_exponentiation_unit: FAILED **");
        $finish;
      end
    end
  end

  // start stays high across back-to-back bases, so it is only lowered on a gap
  task automatic send_base(input logic [modexp_pkg::FIELD_W-1:0] b);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    base_value <= b;
    do @(posedge clk); while (busy);
    pending_powers.push_back(power_mod(b, modulus_copy, exponent_copy));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_key(input logic [modexp_pkg::FIELD_W-1:0] m,
                          input logic [modexp_pkg::FIELD_W-1:0] e);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= modexp_pkg::REG_MODULUS;
    cfg_data <= m;
    @(posedge clk);
    cfg_index <= modexp_pkg::REG_EXPONENT;
    cfg_data <= e;
    @(posedge clk);
    cfg_write <= 1'b0;
    modulus_copy = m;
    exponent_copy = e;
  endtask

  task automatic test_reset_values();
    send_base('0);
    send_base(32'd1);
    send_base(ALL_ONES);
    send_base(32'hFFFF_FFFE);
  endtask

  task automatic test_special_moduli();
    load_key(32'd1, $urandom);
    send_base('0);
    send_base(32'd5);
    send_base(ALL_ONES);
    // no reduction defined: block answers zero
    load_key('0, 32'd65537);
    send_base(32'd7);
    send_base(ALL_ONES);
    send_base('0);
    // empty exponent gives 1 mod n
    load_key(ALL_ONES, '0);
    send_base('0);
    send_base(32'd1234);
    load_key(32'd1, '0);
    send_base(32'd9);
  endtask

  task automatic test_field_extremes();
    load_key(ALL_ONES, ALL_ONES);
    send_base('0);
    send_base(32'd1);
    send_base(ALL_ONES);
    send_base(32'hFFFF_FFFE);
    send_base(32'h8000_0000);
    // base above the modulus must be reduced first
    load_key(32'hFFFF_FFFB, 32'd65537);
    send_base(ALL_ONES);
    send_base(32'd2);
    load_key(32'h8000_0000, 32'd3);
    send_base(32'h7FFF_FFFF);
  endtask

  // textbook key n = 61 * 53, e = 17, d = 2753
  task automatic test_rsa_round_trip();
    logic [modexp_pkg::FIELD_W-1:0] ciphers[$];
    logic [modexp_pkg::FIELD_W-1:0] msg;
    load_key(32'd3233, 32'd17);
    repeat (10) begin
      msg = $urandom_range(0, 3232);
      ciphers.push_back(power_mod(msg, modulus_copy, exponent_copy));
      send_base(msg);
    end
    load_key(32'd3233, 32'd2753);
    foreach (ciphers[i]) send_base(ciphers[i]);
  endtask

  function automatic logic [modexp_pkg::FIELD_W-1:0] pick_modulus();
    case ($urandom_range(0, 9))
      0: return ALL_ONES;
      1: return $urandom_range(0, 1);
      2, 3: return $urandom_range(2, 255);
      default: return $urandom;
    endcase
  endfunction

  // shorter exponents keep most bases cheap; the all-ones and fully random picks use the full width
  function automatic logic [modexp_pkg::FIELD_W-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [modexp_pkg::FIELD_W-1:0] pick_base(
      input logic [modexp_pkg::FIELD_W-1:0] m);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return m;
      3: return m - 1;
      4, 5: return (m == 0) ? $urandom : $urandom % m;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_keys();
    repeat (10) begin
      load_key(pick_modulus(), pick_exponent());
      repeat (25) send_base(pick_base(modulus_copy));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_special_moduli();
    test_field_extremes();
    test_rsa_round_trip();
    test_random_keys();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** modular_exponentiation_unit: PASSED **");
    end else begin
      $display("** modular_exponentiation_unit: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
rtl/modexp_pkg.sv
rtl/modular_exponentiation_unit.sv
bench/tb.sv
